>>> sv/ulea_pkg.sv
package ulea_pkg;

  localparam int unsigned AVG_W  = 22;
  localparam int unsigned CPU_W  = 11;
  localparam int unsigned TICK_W = 64;
  localparam int unsigned PC_W   = 4;

  localparam logic [AVG_W-1:0] AVG_MAX = '1;

  // decay factors in Q11 for the one, five and fifteen minute averages
  localparam logic [10:0] DECAY_ONE_Q11     = 11'd1884;
  localparam logic [10:0] DECAY_FIVE_Q11    = 11'd2014;
  localparam logic [10:0] DECAY_FIFTEEN_Q11 = 11'd2037;

  localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
  localparam logic [PC_W-1:0] PC_DELTA = 4'd1;
  localparam logic [PC_W-1:0] PC_TOTAL = 4'd2;
  localparam logic [PC_W-1:0] PC_SHIFT = 4'd3;
  localparam logic [PC_W-1:0] PC_ADDK  = 4'd4;
  localparam logic [PC_W-1:0] PC_SAT   = 4'd5;
  localparam logic [PC_W-1:0] PC_OUT   = 4'd15;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_DELTA,
    OP_TOTAL,
    OP_SHIFT,
    OP_ADDK,
    OP_SAT,
    OP_MULC,
    OP_MULW,
    OP_WB,
    OP_OUT
  } ulea_op_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_NO_START,
    C_NOT_PRIMED,
    C_DEN_ZERO,
    C_CNT_LEFT,
    C_OUT_BUSY
  } ulea_cond_e;

  typedef enum logic [1:0] {
    LANE_ONE,
    LANE_FIVE,
    LANE_FIFTEEN
  } ulea_lane_e;

  typedef struct packed {
    ulea_op_e          op;
    ulea_lane_e        lane;
    ulea_cond_e        cond;
    logic [PC_W-1:0]   target;
  } ulea_ctrl_t;

  typedef struct packed {
    logic start;
    logic primed;
    logic den_zero;
    logic cnt_left;
    logic out_busy;
  } ulea_status_t;

  // microprogram, one control word per step; the last step wraps to the wait step
  function automatic ulea_ctrl_t ulea_rom(input logic [PC_W-1:0] pc);
    ulea_ctrl_t w;
    w = '{op: OP_OUT, lane: LANE_ONE, cond: C_NONE, target: PC_WAIT};
    unique case (pc)
      4'd0:  w = '{op: OP_WAIT,  lane: LANE_ONE,     cond: C_NO_START,   target: PC_WAIT};
      4'd1:  w = '{op: OP_DELTA, lane: LANE_ONE,     cond: C_NOT_PRIMED, target: PC_OUT};
      4'd2:  w = '{op: OP_TOTAL, lane: LANE_ONE,     cond: C_DEN_ZERO,   target: PC_SAT};
      4'd3:  w = '{op: OP_SHIFT, lane: LANE_ONE,     cond: C_NONE,       target: PC_WAIT};
      4'd4:  w = '{op: OP_ADDK,  lane: LANE_ONE,     cond: C_CNT_LEFT,   target: PC_SHIFT};
      4'd5:  w = '{op: OP_SAT,   lane: LANE_ONE,     cond: C_NONE,       target: PC_WAIT};
      4'd6:  w = '{op: OP_MULC,  lane: LANE_ONE,     cond: C_NONE,       target: PC_WAIT};
      4'd7:  w = '{op: OP_MULW,  lane: LANE_ONE,     cond: C_NONE,       target: PC_WAIT};
      4'd8:  w = '{op: OP_WB,    lane: LANE_ONE,     cond: C_NONE,       target: PC_WAIT};
      4'd9:  w = '{op: OP_MULC,  lane: LANE_FIVE,    cond: C_NONE,       target: PC_WAIT};
      4'd10: w = '{op: OP_MULW,  lane: LANE_FIVE,    cond: C_NONE,       target: PC_WAIT};
      4'd11: w = '{op: OP_WB,    lane: LANE_FIVE,    cond: C_NONE,       target: PC_WAIT};
      4'd12: w = '{op: OP_MULC,  lane: LANE_FIFTEEN, cond: C_NONE,       target: PC_WAIT};
      4'd13: w = '{op: OP_MULW,  lane: LANE_FIFTEEN, cond: C_NONE,       target: PC_WAIT};
      4'd14: w = '{op: OP_WB,    lane: LANE_FIFTEEN, cond: C_NONE,       target: PC_WAIT};
      4'd15: w = '{op: OP_OUT,   lane: LANE_ONE,     cond: C_OUT_BUSY,   target: PC_OUT};
      default: w = '{op: OP_OUT, lane: LANE_ONE, cond: C_NONE, target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> sv/ulea_if.sv
interface ulea_cfg_if;
  import ulea_pkg::*;
  logic             valid;
  logic             ready;
  logic [CPU_W-1:0] cpu_count;

  modport source (output valid, output cpu_count, input ready);
  modport sink   (input valid, input cpu_count, output ready);
endinterface

interface ulea_sample_if;
  import ulea_pkg::*;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] busy_ticks;
  logic [TICK_W-1:0] idle_ticks;

  modport source (output valid, output busy_ticks, output idle_ticks, input ready);
  modport sink   (input valid, input busy_ticks, input idle_ticks, output ready);
endinterface

interface ulea_result_if;
  import ulea_pkg::*;
  logic             valid;
  logic             ready;
  logic [AVG_W-1:0] load_one_min;
  logic [AVG_W-1:0] load_five_min;
  logic [AVG_W-1:0] load_fifteen_min;
  logic             updated;

  modport source (output valid, output load_one_min, output load_five_min,
                  output load_fifteen_min, output updated, input ready);
  modport sink   (input valid, input load_one_min, input load_five_min,
                  input load_fifteen_min, input updated, output ready);
endinterface

>>> sv/ulea_seq.sv
module ulea_seq
  import ulea_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ulea_status_t status_i,
  output ulea_ctrl_t   ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  logic            take;

  assign ctrl_o = ulea_rom(pc_q);

  always_comb begin
    unique case (ctrl_o.cond)
      C_NONE:       take = 1'b0;
      C_NO_START:   take = !status_i.start;
      C_NOT_PRIMED: take = !status_i.primed;
      C_DEN_ZERO:   take = status_i.den_zero;
      C_CNT_LEFT:   take = status_i.cnt_left;
      C_OUT_BUSY:   take = status_i.out_busy;
      default:      take = 1'b0;
    endcase
    pc_d = take ? ctrl_o.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> sv/utilization_load_average_ewma_top.sv
// channel   | dir | modport | word
// ----------+-----+---------+-------------------------------------------------
// cfg_i     | in  | sink    | cpu_count (11 bits), always ready
// sample_i  | in  | sink    | busy_ticks, idle_ticks (64 bits each, cumulative)
// result_o  | out | source  | load_one_min/five/fifteen (22 bits Q), updated
//
// an accepted sample passes the delta, total, divide (a shift and an add step
// per quotient bit, 11+FRAC_BITS bits), saturate, fold and output steps; a new
// sample is taken at the wait step after output; a priming sample goes from
// delta straight to output, and a zero tick total skips the divide loop
// reset clears the stored totals, the averages and the primed flag, and
// sets cpu_count to 1; no clearing pass is needed
// a result that is not taken holds the sequencer at its output step, but the
// result register lets the next sample in as soon as that step is passed
module utilization_load_average_ewma_top
  import ulea_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ulea_cfg_if.sink             cfg_i,
  ulea_sample_if.sink          sample_i,
  ulea_result_if.source        result_o
);

  // width of the load scale k = cpu_count << FRAC_BITS, also the quotient width
  localparam int unsigned KW = CPU_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(KW);
  // remainder holds up to twice the 65-bit divisor
  localparam int unsigned RW = TICK_W + 2;
  localparam int unsigned DW = TICK_W + 1;
  localparam int unsigned BW = FRAC_BITS + 1;
  localparam int unsigned AW = AVG_W + BW;

  // decay factors rescaled from Q11 to the chosen fraction width
  localparam logic [BW-1:0] C_ONE =
    BW'((32'(DECAY_ONE_Q11) << FRAC_BITS) >> 11);
  localparam logic [BW-1:0] C_FIVE =
    BW'((32'(DECAY_FIVE_Q11) << FRAC_BITS) >> 11);
  localparam logic [BW-1:0] C_FIFTEEN =
    BW'((32'(DECAY_FIFTEEN_Q11) << FRAC_BITS) >> 11);
  localparam logic [BW-1:0] SCALE = BW'(1) << FRAC_BITS;

  ulea_ctrl_t   ctrl;
  ulea_status_t status;

  // configuration and architectural state
  logic [CPU_W-1:0]  cpu_q;
  logic [TICK_W-1:0] prev_busy_q, prev_idle_q;
  logic              primed_q;
  logic [AVG_W-1:0]  avg_one_q, avg_five_q, avg_fifteen_q;

  // working registers
  logic [TICK_W-1:0] busy_q, idle_q;
  logic [TICK_W-1:0] dbusy_q, didle_q;
  logic [DW-1:0]     den_q;
  logic [RW-1:0]     r_q;
  logic [KW-1:0]     q_q;
  logic [CW-1:0]     cnt_q;
  logic [AVG_W-1:0]  load_q;
  logic [AW-1:0]     acc_q;
  logic              upd_q;

  // result register
  logic              res_valid_q;
  logic [AVG_W-1:0]  res_one_q, res_five_q, res_fifteen_q;
  logic              res_upd_q;

  logic              out_busy;
  logic [DW-1:0]     den_sum;
  logic [KW-1:0]     k_w;
  logic              kbit;
  logic [RW-1:0]     t_sh, t_add, den_ext;
  logic              ge_sh, ge_add;
  logic [31:0]       q_ext;
  logic [BW-1:0]     c_sel, w_sel, mul_b;
  logic [AVG_W-1:0]  avg_sel, mul_a;
  logic [AW-1:0]     prod;

  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = (ctrl.op == OP_WAIT);

  assign out_busy = res_valid_q && !result_o.ready;

  assign status = '{
    start:    sample_i.valid,
    primed:   primed_q,
    den_zero: (den_sum == '0),
    cnt_left: (cnt_q != '0),
    out_busy: out_busy
  };

  ulea_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // divide datapath: one compare-subtract per step
  assign den_sum = {1'b0, dbusy_q} + {1'b0, didle_q};
  assign k_w     = {cpu_q, FRAC_BITS'(0)};
  assign kbit    = k_w[cnt_q];
  assign den_ext = {1'b0, den_q};
  assign t_sh    = {r_q[RW-2:0], 1'b0};
  assign ge_sh   = (t_sh >= den_ext);
  assign t_add   = r_q + {2'b00, dbusy_q};
  assign ge_add  = (t_add >= den_ext);
  assign q_ext   = 32'(q_q);

  // one shared multiplier for the three folds
  always_comb begin
    unique case (ctrl.lane)
      LANE_ONE: begin
        c_sel   = C_ONE;
        avg_sel = avg_one_q;
      end
      LANE_FIVE: begin
        c_sel   = C_FIVE;
        avg_sel = avg_five_q;
      end
      LANE_FIFTEEN: begin
        c_sel   = C_FIFTEEN;
        avg_sel = avg_fifteen_q;
      end
      default: begin
        c_sel   = '0;
        avg_sel = '0;
      end
    endcase
    w_sel = SCALE - c_sel;
    mul_a = (ctrl.op == OP_MULC) ? avg_sel : load_q;
    mul_b = (ctrl.op == OP_MULC) ? c_sel : w_sel;
    prod  = AW'(mul_a) * AW'(mul_b);
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_q         <= CPU_W'(1);
      prev_busy_q   <= '0;
      prev_idle_q   <= '0;
      primed_q      <= 1'b0;
      avg_one_q     <= '0;
      avg_five_q    <= '0;
      avg_fifteen_q <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        cpu_q <= cfg_i.cpu_count;
      end
      if (ctrl.op == OP_DELTA) begin
        prev_busy_q <= busy_q;
        prev_idle_q <= idle_q;
        primed_q    <= 1'b1;
      end
      if (ctrl.op == OP_WB) begin
        unique case (ctrl.lane)
          LANE_ONE:     avg_one_q     <= acc_q[FRAC_BITS +: AVG_W];
          LANE_FIVE:    avg_five_q    <= acc_q[FRAC_BITS +: AVG_W];
          LANE_FIFTEEN: avg_fifteen_q <= acc_q[FRAC_BITS +: AVG_W];
          default: ;
        endcase
      end
      if (ctrl.op == OP_OUT && !out_busy) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (ctrl.op)
      OP_WAIT: begin
        if (sample_i.valid) begin
          busy_q <= sample_i.busy_ticks;
          idle_q <= sample_i.idle_ticks;
        end
      end
      OP_DELTA: begin
        dbusy_q <= busy_q - prev_busy_q;
        didle_q <= idle_q - prev_idle_q;
        upd_q   <= primed_q;
      end
      OP_TOTAL: begin
        den_q <= den_sum;
        r_q   <= '0;
        q_q   <= '0;
        cnt_q <= CW'(KW - 1);
      end
      OP_SHIFT: begin
        r_q <= ge_sh ? t_sh - den_ext : t_sh;
        q_q <= {q_q[KW-2:0], ge_sh};
      end
      OP_ADDK: begin
        if (kbit) begin
          r_q <= ge_add ? t_add - den_ext : t_add;
          q_q <= q_q + KW'(ge_add);
        end
        cnt_q <= cnt_q - CW'(1);
      end
      OP_SAT: begin
        load_q <= (q_ext > 32'(AVG_MAX)) ? AVG_MAX : q_ext[AVG_W-1:0];
      end
      OP_MULC: begin
        acc_q <= prod;
      end
      OP_MULW: begin
        acc_q <= acc_q + prod;
      end
      OP_WB: ;
      OP_OUT: begin
        if (!out_busy) begin
          res_one_q     <= avg_one_q;
          res_five_q    <= avg_five_q;
          res_fifteen_q <= avg_fifteen_q;
          res_upd_q     <= upd_q;
        end
      end
      default: ;
    endcase
  end

  assign result_o.valid            = res_valid_q;
  assign result_o.load_one_min     = res_one_q;
  assign result_o.load_five_min    = res_five_q;
  assign result_o.load_fifteen_min = res_fifteen_q;
  assign result_o.updated          = res_upd_q;

  // remainder stays below the divisor throughout the divide loop
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_SHIFT || ctrl.op == OP_ADDK) |-> (r_q < den_ext))
    else $error("divide remainder not below divisor");

  // an accepted sample goes straight on to the delta step
  a_accept_to_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> (ctrl.op == OP_DELTA))
    else $error("accepted sample not followed by delta step");

  // an updated result can only follow a primed state
  a_updated_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.updated) |-> primed_q)
    else $error("updated result without priming sample");

  // result register is loaded only from the output step
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> ($past(ctrl.op) == OP_OUT))
    else $error("result loaded outside the output step");

endmodule

>>> bench/tb.sv
module tb;
  import ulea_pkg::*;

  localparam int unsigned FRAC      = 11;
  // cycles with no word moving on any channel before the run is called hung
  localparam int unsigned HANG_LIMIT = 4000;
  // long receiver hold-off, well past what the block can buffer
  localparam int unsigned LONG_HOLD = 400;
  // settle after the last result, longer than a sample takes to its result
  localparam int unsigned TAIL_WAIT = 100;
  localparam int unsigned PHASE_ITEMS = 222;

  // one sample word as offered to the block
  typedef struct packed {
    logic [TICK_W-1:0] busy;
    logic [TICK_W-1:0] idle;
  } tick_sample_t;

  // one result word
  typedef struct packed {
    logic [AVG_W-1:0] one_min;
    logic [AVG_W-1:0] five_min;
    logic [AVG_W-1:0] fifteen_min;
    logic             updated;
  } load_avg_t;

  logic clk_i;
  logic rst_ni;

  ulea_cfg_if    cfg_bus ();
  ulea_sample_if smp_bus ();
  ulea_result_if res_bus ();

  utilization_load_average_ewma_top #(
    .FRAC_BITS (FRAC)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .sample_i (smp_bus),
    .result_o (res_bus)
  );

  // clock, period 2
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shared bench state
  // ---------------------------------------------------------------------------
  tick_sample_t sample_q[$];      // words waiting to be offered
  load_avg_t    avg_expect_q[$];  // predicted results, oldest first

  int unsigned words_sent;        // sample words put on the bus
  int unsigned words_taken;       // sample words accepted by the block
  int unsigned cfg_writes;        // register writes seen on the bus
  int unsigned hold_requests;     // long hold-offs asked for
  int unsigned holds_served;      // long hold-offs started by the receiver
  int unsigned send_idle_pct;     // sender idle chance per cycle
  int unsigned recv_stall_pct;    // receiver stall chance per cycle
  int unsigned error_count;
  int unsigned quiet_cycles;

  // generator running totals, so that most samples form sensible deltas
  logic [TICK_W-1:0] gen_busy;
  logic [TICK_W-1:0] gen_idle;

  // ---------------------------------------------------------------------------
  // predictor: own copy of the block state and the register
  // ---------------------------------------------------------------------------
  logic [CPU_W-1:0]  cpus;
  logic [TICK_W-1:0] held_busy;
  logic [TICK_W-1:0] held_idle;
  logic              have_base;
  logic [AVG_W-1:0]  avg_1m;
  logic [AVG_W-1:0]  avg_5m;
  logic [AVG_W-1:0]  avg_15m;

  // instantaneous load, floor(dbusy * cpus * 2^FRAC / (dbusy + didle)), kept exact
  function automatic logic [AVG_W-1:0] sample_load(input logic [TICK_W-1:0] d_busy,
                                                   input logic [TICK_W-1:0] d_idle,
                                                   input logic [CPU_W-1:0]  n_cpu);
    logic [64:0]  total;
    logic [127:0] num;
    logic [127:0] quo;
    total = {1'b0, d_busy} + {1'b0, d_idle};
    // zero tick total gives no load
    if (total == '0) return '0;
    num = 128'(d_busy) * (128'(n_cpu) << FRAC);
    quo = num / 128'(total);
    // saturate, only reachable with a wide fraction
    if (quo > 128'(AVG_MAX)) return AVG_MAX;
    return quo[AVG_W-1:0];
  endfunction

  // one decay step: (c*old + load*(2^FRAC - c)) >> FRAC, c rescaled from Q11
  function automatic logic [AVG_W-1:0] decay_fold(input logic [AVG_W-1:0] old_avg,
                                                  input logic [AVG_W-1:0] load,
                                                  input logic [10:0]      c_q11);
    logic [63:0] c;
    logic [63:0] acc;
    c   = (64'(c_q11) << FRAC) >> 11;
    acc = c * 64'(old_avg) + 64'(load) * ((64'd1 << FRAC) - c);
    acc = acc >> FRAC;
    return acc[AVG_W-1:0];
  endfunction

  // advance the averages for one accepted sample and queue the result it causes
  task automatic advance_averages(input tick_sample_t s);
    logic [AVG_W-1:0] load;
    load_avg_t        res;
    res.updated = 1'b0;
    if (!have_base) begin
      // priming sample: store totals only
      have_base = 1'b1;
    end else begin
      // deltas wrap modulo 2^64
      load    = sample_load(s.busy - held_busy, s.idle - held_idle, cpus);
      avg_1m  = decay_fold(avg_1m,  load, DECAY_ONE_Q11);
      avg_5m  = decay_fold(avg_5m,  load, DECAY_FIVE_Q11);
      avg_15m = decay_fold(avg_15m, load, DECAY_FIFTEEN_Q11);
      res.updated = 1'b1;
    end
    held_busy       = s.busy;
    held_idle       = s.idle;
    res.one_min     = avg_1m;
    res.five_min    = avg_5m;
    res.fifteen_min = avg_15m;
    avg_expect_q.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // monitor: sample every channel at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_bus
    tick_sample_t acc_word;
    load_avg_t    got;
    load_avg_t    want;
    logic         moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_bus.valid && cfg_bus.ready) begin
        cpus = cfg_bus.cpu_count;
        cfg_writes++;
        moved = 1'b1;
      end
      if (smp_bus.valid && smp_bus.ready) begin
        acc_word.busy = smp_bus.busy_ticks;
        acc_word.idle = smp_bus.idle_ticks;
        advance_averages(acc_word);
        words_taken++;
        moved = 1'b1;
      end
      if (res_bus.valid && res_bus.ready) begin
        moved           = 1'b1;
        got.one_min     = res_bus.load_one_min;
        got.five_min    = res_bus.load_five_min;
        got.fifteen_min = res_bus.load_fifteen_min;
        got.updated     = res_bus.updated;
        if (avg_expect_q.size() == 0) begin
          error_count++;
          $display("%0t: result word with none expected, expected none", $time);
          $display("%0t:   actual one %0d five %0d fifteen %0d upd %0d",
                   $time, got.one_min, got.five_min, got.fifteen_min, got.updated);
        end else begin
          want = avg_expect_q.pop_front();
          if (got !== want) begin
            error_count++;
            $display("%0t: result mismatch, expected one %0d five %0d fifteen %0d upd %0d",
                     $time, want.one_min, want.five_min, want.fifteen_min, want.updated);
            $display("%0t:                  actual   one %0d five %0d fifteen %0d upd %0d",
                     $time, got.one_min, got.five_min, got.fifteen_min, got.updated);
          end
        end
      end
      // watchdog on words moving anywhere
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("utilization_load_average_ewma_top verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sample driver: fed from sample_q, changes at the falling edge
  // ---------------------------------------------------------------------------
  int unsigned send_gap;

  always @(negedge clk_i) begin : drive_samples
    tick_sample_t nxt;
    logic         nxt_valid;
    if (rst_ni) begin
      nxt_valid = smp_bus.valid;
      // word taken at the last rising edge
      if (smp_bus.valid && words_taken == words_sent) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_q.size() > 0) begin
          if ($urandom_range(0, 99) < send_idle_pct) begin
            // now and then a long gap, so that it lands on every step of the work
            if ($urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 120);
          end else begin
            nxt = sample_q.pop_front();
            nxt_valid = 1'b1;
            words_sent++;
            smp_bus.busy_ticks <= nxt.busy;
            smp_bus.idle_ticks <= nxt.idle;
          end
        end
      end
      smp_bus.valid <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls plus the long hold-off, counted here
  // ---------------------------------------------------------------------------
  int unsigned hold_left;

  always @(negedge clk_i) begin : drive_ready
    logic rdy;
    rdy = 1'b1;
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if ($urandom_range(0, 99) < recv_stall_pct) begin
      rdy = 1'b0;
    end
    res_bus.ready <= rdy && rst_ni;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [TICK_W-1:0] rand_ticks();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_sample(input logic [TICK_W-1:0] busy, input logic [TICK_W-1:0] idle);
    tick_sample_t s;
    s.busy   = busy;
    s.idle   = idle;
    gen_busy = busy;
    gen_idle = idle;
    sample_q.push_back(s);
  endtask

  // mostly running totals with random deltas, some wraps, zero totals and noise
  task automatic queue_random_sample();
    int unsigned       pick;
    logic [TICK_W-1:0] d_busy;
    logic [TICK_W-1:0] d_idle;
    pick   = $urandom_range(0, 99);
    d_busy = rand_ticks() >> $urandom_range(20, 63);
    d_idle = rand_ticks() >> $urandom_range(20, 63);
    if (pick < 60) begin
      // ordinary deltas
    end else if (pick < 68) begin
      d_busy = '0;
      d_idle = '0;
    end else if (pick < 72) begin
      d_idle = '0;
    end else if (pick < 76) begin
      d_busy = '0;
    end else if (pick < 82) begin
      // park totals just short of the top so the next deltas wrap
      gen_busy = ~64'($urandom_range(0, 2000));
      gen_idle = ~64'($urandom_range(0, 2000));
    end else if (pick < 90) begin
      queue_sample(rand_ticks(), rand_ticks());
      return;
    end else begin
      // huge deltas, the sum can overflow 64 bits
      d_busy = rand_ticks();
      d_idle = rand_ticks();
    end
    queue_sample(gen_busy + d_busy, gen_idle + d_idle);
  endtask

  // sender pause: nothing new until every expected result has come
  task automatic wait_drained();
    while (sample_q.size() != 0 || words_taken != words_sent || avg_expect_q.size() != 0)
      @(posedge clk_i);
  endtask

  // register write, only while the block is idle
  task automatic write_cpu_count(input logic [CPU_W-1:0] val);
    int unsigned seen;
    seen = cfg_writes;
    @(negedge clk_i);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.cpu_count <= val;
    do @(negedge clk_i); while (cfg_writes == seen);
    cfg_bus.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int unsigned      base;
    logic [CPU_W-1:0] cpu_plan [8];

    // every input known from the start
    rst_ni             = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.cpu_count  = '0;
    smp_bus.valid      = 1'b0;
    smp_bus.busy_ticks = '0;
    smp_bus.idle_ticks = '0;
    res_bus.ready      = 1'b0;
    words_sent = 0; words_taken = 0; cfg_writes = 0;
    hold_requests = 0; holds_served = 0; hold_left = 0; send_gap = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    error_count = 0; quiet_cycles = 0;
    gen_busy = '0; gen_idle = '0;
    // predictor reset state
    cpus = CPU_W'(1); held_busy = '0; held_idle = '0; have_base = 1'b0;
    avg_1m = '0; avg_5m = '0; avg_15m = '0;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, cpu_count at its reset value
    queue_sample(64'd0, 64'd0);                 // priming sample
    queue_sample(64'd0, 64'd0);                 // zero tick total
    queue_sample(64'd100, 64'd0);               // all busy
    queue_sample(64'd100, 64'd0);               // zero total again
    queue_sample(64'd100, 64'd300);             // all idle
    queue_sample('1, 64'd300);                  // near full-range busy delta
    queue_sample(64'd49, '1);                   // busy wraps, idle huge
    queue_sample('1, ~64'd1);                   // both huge, sum past 64 bits
    queue_sample(64'd0, 64'd0);                 // both wrap by small amounts
    queue_sample(64'd700, 64'd300);
    queue_sample(64'd1000, 64'd1300);
    queue_sample(64'd1001, 64'd1300);
    wait_drained();

    // widest register value
    write_cpu_count('1);
    queue_sample(gen_busy + 64'd500, gen_idle);
    queue_sample(gen_busy + 64'd500, gen_idle);
    queue_sample(gen_busy + 64'd250, gen_idle + 64'd250);
    queue_sample(gen_busy + 64'hFFFF_FFFF_FFFF_FFF0, gen_idle + 64'd3);
    wait_drained();

    // zero processors, load is 0
    write_cpu_count('0);
    queue_sample(gen_busy + 64'd90, gen_idle);
    queue_sample(gen_busy + 64'd90, gen_idle + 64'd10);
    queue_sample(gen_busy + rand_ticks(), gen_idle + rand_ticks());
    wait_drained();

    write_cpu_count(11'd1024);
    repeat (5) queue_sample(gen_busy + 64'd64, gen_idle);
    wait_drained();

    // random phases: idling mode cycles, register changes between them
    cpu_plan[0] = 11'd1;
    cpu_plan[1] = '1;
    cpu_plan[2] = 11'd1024;
    cpu_plan[3] = CPU_W'($urandom_range(2, 2046));
    cpu_plan[4] = '0;
    cpu_plan[5] = 11'd3;
    cpu_plan[6] = CPU_W'($urandom_range(2, 2046));
    cpu_plan[7] = 11'd1024;

    for (int sp = 0; sp < 8; sp++) begin
      write_cpu_count(cpu_plan[sp]);
      case (sp % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      base = words_taken;
      repeat (PHASE_ITEMS) queue_random_sample();
      if (sp % 4 == 0) begin
        // back-pressure: results held off while the sender keeps offering
        while (words_taken < base + 5) @(posedge clk_i);
        hold_requests++;
      end
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (error_count == 0 && avg_expect_q.size() == 0)
      $display("utilization_load_average_ewma_top verification clean");
    else
      $display("utilization_load_average_ewma_top verification failed");
    $finish;
  end

endmodule

>>> filelist.f
sv/ulea_pkg.sv
sv/ulea_if.sv
sv/ulea_seq.sv
sv/utilization_load_average_ewma_top.sv
bench/tb.sv
